FILE: hw/rtl/rsym_pkg.sv
// Shared types and constants for the signed integer to radix symbol converter.
// Used by the front, back and top level; depends on nothing.
package rsym_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIX    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMS_LOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMS_HIGH = 2'd2;

  localparam int unsigned RADIX_W  = 5;
  localparam int unsigned SYM_W    = 8;
  localparam int unsigned NUM_SYMS = 16;
  localparam int unsigned SYMS_W   = SYM_W * NUM_SYMS;
  localparam int unsigned CFG_W    = 64;

  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
  localparam logic [RADIX_W-1:0] MIN_RADIX = 5'd2;

  // Dividend bits retired per cycle by the digit divider.
  localparam int unsigned DIV_STEPS = 8;

  // Live configuration as seen by the back end.
  typedef struct packed {
    logic [RADIX_W-1:0] radix;
    logic [SYMS_W-1:0]  symbols;
  } cfg_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_SIGN,
    BK_RD,
    BK_LD
  } bk_state_t;

endpackage

FILE: hw/rtl/rsym_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rsym_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/rsym_fifo.sv
// Short queue of classified words between the front and back ends.
// No dependencies.
module rsym_fifo #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: hw/rtl/rsym_front.sv
// Front end: configuration registers, alphabet check, and sign/magnitude split.
// Depends on rsym_pkg.
module rsym_front #(
  parameter int unsigned MAX_BASE    = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rsym_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rsym_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [VALUE_WIDTH-1:0]     in_value,
  input  logic                              q_full,
  output logic                              q_push,
  output logic [VALUE_WIDTH:0]              q_data,
  output rsym_pkg::cfg_t                    cfg
);

  logic [rsym_pkg::RADIX_W-1:0] radix_r, radix_nxt;
  logic [rsym_pkg::CFG_W-1:0]   syms_lo_r, syms_lo_nxt;
  logic [rsym_pkg::CFG_W-1:0]   syms_hi_r, syms_hi_nxt;
  logic                         ok_r, ok_nxt;
  logic                         neg;
  logic [VALUE_WIDTH-1:0]       mag;

  // True when the radix is usable and the first radix symbols are legal and distinct.
  function automatic logic alphabet_ok(input logic [rsym_pkg::RADIX_W-1:0] radix,
                                       input logic [rsym_pkg::SYMS_W-1:0] syms);
    logic                       ok;
    logic [rsym_pkg::SYM_W-1:0] si;
    ok = (radix >= rsym_pkg::MIN_RADIX) &&
         (radix <= rsym_pkg::RADIX_W'(MAX_BASE));
    for (int i = 0; i < rsym_pkg::NUM_SYMS; i++) begin
      si = syms[i*rsym_pkg::SYM_W +: rsym_pkg::SYM_W];
      if (rsym_pkg::RADIX_W'(i) < radix) begin
        if (si == '0 || si == rsym_pkg::SYM_PLUS || si == rsym_pkg::SYM_MINUS) begin
          ok = 1'b0;
        end
        for (int j = i + 1; j < rsym_pkg::NUM_SYMS; j++) begin
          if (rsym_pkg::RADIX_W'(j) < radix &&
              si == syms[j*rsym_pkg::SYM_W +: rsym_pkg::SYM_W]) begin
            ok = 1'b0;
          end
        end
      end
    end
    return ok;
  endfunction

  always_comb begin
    radix_nxt   = radix_r;
    syms_lo_nxt = syms_lo_r;
    syms_hi_nxt = syms_hi_r;
    if (cfg_we) begin
      case (cfg_index)
        rsym_pkg::REG_RADIX:     radix_nxt   = cfg_data[rsym_pkg::RADIX_W-1:0];
        rsym_pkg::REG_SYMS_LOW:  syms_lo_nxt = cfg_data;
        rsym_pkg::REG_SYMS_HIGH: syms_hi_nxt = cfg_data;
        default: ;
      endcase
    end
    // The check follows the next register values so it is current as soon as
    // the write lands.
    ok_nxt = alphabet_ok(radix_nxt, {syms_hi_nxt, syms_lo_nxt});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r   <= '0;
      syms_lo_r <= '0;
      syms_hi_r <= '0;
      ok_r      <= 1'b0;
    end else begin
      radix_r   <= radix_nxt;
      syms_lo_r <= syms_lo_nxt;
      syms_hi_r <= syms_hi_nxt;
      ok_r      <= ok_nxt;
    end
  end

  // The negated minimum value wraps to itself, which is the right magnitude.
  assign neg = in_value[VALUE_WIDTH-1];
  assign mag = neg ? (~in_value + 1'b1) : in_value;

  // Words with an invalid alphabet are taken and dropped.
  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready && ok_r;
  assign q_data   = {neg, mag};

  assign cfg.radix   = radix_r;
  assign cfg.symbols = {syms_hi_r, syms_lo_r};

endmodule

FILE: hw/rtl/rsym_back.sv
// Back end: repeated division into a digit stack, then sign and symbol emission.
// Depends on rsym_pkg and rsym_ram.
module rsym_back #(
  parameter int unsigned MAX_BASE    = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rsym_pkg::cfg_t              cfg,
  input  logic                        q_empty,
  input  logic [VALUE_WIDTH:0]        q_data,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rsym_pkg::SYM_W-1:0]  out_symbol,
  output logic                        out_last
);

  localparam int unsigned DIG_W  = $clog2(MAX_BASE);
  localparam int unsigned RAD_W  = DIG_W + 1;
  localparam int unsigned STEPS  = rsym_pkg::DIV_STEPS;
  localparam int unsigned PAD_W  = ((VALUE_WIDTH + STEPS - 1) / STEPS) * STEPS;
  localparam int unsigned NCYC   = PAD_W / STEPS;
  localparam int unsigned STEP_W = (NCYC > 1) ? $clog2(NCYC) : 1;
  localparam int unsigned CNT_W  = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned AW     = $clog2(VALUE_WIDTH);

  rsym_pkg::bk_state_t state_r, state_nxt;

  logic [PAD_W-1:0]            q_r, q_nxt, q_div;
  logic [DIG_W-1:0]            rem_r, rem_nxt, rem_div;
  logic                        neg_r, neg_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt, cnt_dec;
  logic [STEP_W-1:0]           step_r, step_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [rsym_pkg::SYM_W-1:0]  out_symbol_r, out_symbol_nxt;
  logic                        out_last_r, out_last_nxt;
  logic                        out_free;
  logic                        last_step;
  logic [RAD_W-1:0]            radix;
  logic                        ram_we, ram_re;
  logic [DIG_W-1:0]            ram_rdata;
  logic [3:0]                  sym_idx;
  logic [rsym_pkg::SYM_W-1:0]  sym;

  // The radix is known to be in range once a word reaches the queue.
  assign radix     = cfg.radix[RAD_W-1:0];
  assign out_free  = !out_valid_r || out_ready;
  assign last_step = (step_r == STEP_W'(NCYC - 1));
  assign cnt_dec   = cnt_r - 1'b1;

  // Long division, STEPS dividend bits per cycle; the quotient shifts in
  // behind the dividend bits as they leave.
  always_comb begin
    logic [DIG_W:0] t;
    q_div   = q_r;
    rem_div = rem_r;
    for (int k = 0; k < STEPS; k++) begin
      t     = {rem_div, q_div[PAD_W-1]};
      q_div = {q_div[PAD_W-2:0], 1'b0};
      if (t >= radix) begin
        t        = t - radix;
        q_div[0] = 1'b1;
      end
      rem_div = t[DIG_W-1:0];
    end
  end

  rsym_ram #(
    .WIDTH(DIG_W),
    .DEPTH(VALUE_WIDTH)
  ) u_digits (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cnt_r[AW-1:0]),
    .wdata(rem_div),
    .re   (ram_re),
    .raddr(cnt_dec[AW-1:0]),
    .rdata(ram_rdata)
  );

  assign sym_idx = 4'(ram_rdata);
  assign sym     = cfg.symbols[sym_idx*rsym_pkg::SYM_W +: rsym_pkg::SYM_W];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rsym_pkg::BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = rsym_pkg::BK_DIV;
        end
      end
      rsym_pkg::BK_DIV: begin
        if (last_step && q_div == '0) begin
          state_nxt = neg_r ? rsym_pkg::BK_SIGN : rsym_pkg::BK_RD;
        end
      end
      rsym_pkg::BK_SIGN: begin
        if (out_free) begin
          state_nxt = rsym_pkg::BK_RD;
        end
      end
      rsym_pkg::BK_RD: begin
        state_nxt = rsym_pkg::BK_LD;
      end
      rsym_pkg::BK_LD: begin
        if (out_free) begin
          state_nxt = (cnt_r == CNT_W'(1)) ? rsym_pkg::BK_IDLE : rsym_pkg::BK_RD;
        end
      end
      default: state_nxt = rsym_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_nxt          = q_r;
    rem_nxt        = rem_r;
    neg_nxt        = neg_r;
    cnt_nxt        = cnt_r;
    step_nxt       = step_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_symbol_nxt = out_symbol_r;
    out_last_nxt   = out_last_r;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    case (state_r)
      rsym_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          q_nxt    = PAD_W'(q_data[VALUE_WIDTH-1:0]);
          rem_nxt  = '0;
          neg_nxt  = q_data[VALUE_WIDTH];
          cnt_nxt  = '0;
          step_nxt = '0;
        end
      end
      rsym_pkg::BK_DIV: begin
        q_nxt    = q_div;
        rem_nxt  = rem_div;
        step_nxt = step_r + 1'b1;
        if (last_step) begin
          ram_we   = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
          rem_nxt  = '0;
          step_nxt = '0;
        end
      end
      rsym_pkg::BK_SIGN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_symbol_nxt = rsym_pkg::SYM_MINUS;
          out_last_nxt   = 1'b0;
        end
      end
      rsym_pkg::BK_RD: begin
        ram_re = 1'b1;
      end
      rsym_pkg::BK_LD: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_symbol_nxt = sym;
          out_last_nxt   = (cnt_r == CNT_W'(1));
          cnt_nxt        = cnt_dec;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rsym_pkg::BK_IDLE;
      cnt_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r          <= q_nxt;
    rem_r        <= rem_nxt;
    neg_r        <= neg_nxt;
    out_symbol_r <= out_symbol_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;

endmodule

FILE: hw/rtl/signed_int_to_radix_symbols.sv
// Sequence: the back end pops a word from the queue, runs the divider once per digit,
// then emits a minus sign for negative values and reads the digit stack once per symbol.
// The back end converts one word per run; run length is set by the 8-bit-per-cycle
// divider and the digit stack read per symbol.
// Reset (rst_n, synchronous, active low) clears radix and alphabet to zero, which is
// invalid, empties the queue and returns the back end to idle.
module signed_int_to_radix_symbols #(
  parameter int unsigned MAX_BASE    = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rsym_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rsym_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [VALUE_WIDTH-1:0]    in_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rsym_pkg::SYM_W-1:0]       out_symbol,
  output logic                             out_last
);

  // The front end holds the configuration, checks the alphabet and splits
  // each word into sign and magnitude. Words arriving with an invalid
  // alphabet are accepted and dropped, so they produce no symbols.
  // Classified words wait in a two-entry queue so the front keeps taking
  // input while the back end is busy with a long conversion.
  // The back end divides by the radix until the quotient is zero, pushing
  // each remainder onto a digit stack, then pops the stack so the most
  // significant digit comes out first, with a minus sign ahead of it for
  // negative values. The final symbol of a run carries out_last.

  rsym_pkg::cfg_t         cfg;
  logic                   q_push;
  logic                   q_pop;
  logic                   q_full;
  logic                   q_empty;
  logic [VALUE_WIDTH:0]   q_wdata;
  logic [VALUE_WIDTH:0]   q_rdata;

  rsym_front #(
    .MAX_BASE   (MAX_BASE),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_value (in_value),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata),
    .cfg      (cfg)
  );

  rsym_fifo #(
    .WIDTH(VALUE_WIDTH + 1),
    .DEPTH(2)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_wdata),
    .pop      (q_pop),
    .pop_data (q_rdata),
    .full     (q_full),
    .empty    (q_empty)
  );

  rsym_back #(
    .MAX_BASE   (MAX_BASE),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_symbol(out_symbol),
    .out_last  (out_last)
  );

  // The front never writes a word into a full queue.
  assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
    else $error("queue written while full");

  // The back end never takes a word from an empty queue.
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
    else $error("queue read while empty");

  // A word pushed into an empty queue is visible to the back end next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (q_push && q_empty && !q_pop) |=> !q_empty)
    else $error("queued word lost");

endmodule
